/* hw/rtl/segi_pkg.sv */
// ----------------------------------------------------------------------------
// Segment intersection package
// Shared constants for the segment intersection pipeline.
// ----------------------------------------------------------------------------
package segi_pkg;
	localparam int unsigned DEF_COORD_WIDTH = 16;
	localparam int unsigned FRAC_BITS = 4;
endpackage

/* hw/rtl/segi_div.sv */
// ----------------------------------------------------------------------------
// Segment intersection divider
// Pipelined restoring divider of unsigned magnitudes, one quotient bit a stage.
// ----------------------------------------------------------------------------
module segi_div
	import segi_pkg::*;
#(
	parameter int unsigned NUM_W = 51,
	parameter int unsigned DEN_W = 34,
	parameter int unsigned Q_W = 18,
	parameter int unsigned TAG_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [Q_W-1:0]   quo,
	output logic [TAG_W-1:0] tag_out
);
	localparam int unsigned R_W = DEN_W + 1;

	logic [Q_W:0]             v_q;
	logic [R_W-1:0]           rem_q [Q_W+1];
	logic [NUM_W-1:0]         num_q [Q_W+1];
	logic [DEN_W-1:0]         den_q [Q_W+1];
	logic [Q_W-1:0]           quo_q [Q_W+1];
	logic [TAG_W-1:0]         tag_q [Q_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[Q_W-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= R_W'(num >> Q_W);
			num_q[0] <= num;
			den_q[0] <= den;
			quo_q[0] <= '0;
			tag_q[0] <= tag_in;
			for (int i = 0; i < Q_W; i++) begin
				logic [R_W-1:0] tr;
				tr = {rem_q[i][R_W-2:0], num_q[i][Q_W-1-i]};
				if (tr >= {1'b0, den_q[i]}) begin
					rem_q[i+1] <= tr - {1'b0, den_q[i]};
					quo_q[i+1] <= {quo_q[i][Q_W-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= tr;
					quo_q[i+1] <= {quo_q[i][Q_W-2:0], 1'b0};
				end
				num_q[i+1] <= num_q[i];
				den_q[i+1] <= den_q[i];
				tag_q[i+1] <= tag_q[i];
			end
		end
	end

	assign out_valid = v_q[Q_W];
	assign quo = quo_q[Q_W];
	assign tag_out = tag_q[Q_W];
endmodule

/* hw/rtl/segment_intersection.sv */
// ----------------------------------------------------------------------------
// Segment intersection
// Closed-segment intersection test with intersection point, fully pipelined.
// ----------------------------------------------------------------------------
// One item enters every cycle unless in_stall is high, and its result leaves
// after four arithmetic stages, a divider input stage, one divider stage per
// quotient bit (COORD_WIDTH + 2 of them) and one output stage. A stall at the
// output while a result is valid freezes the whole pipeline, which then holds
// every item.
module segment_intersection
	import segi_pkg::*;
#(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] a_start_x,
	input  logic signed [COORD_WIDTH-1:0] a_start_y,
	input  logic signed [COORD_WIDTH-1:0] a_end_x,
	input  logic signed [COORD_WIDTH-1:0] a_end_y,
	input  logic signed [COORD_WIDTH-1:0] b_start_x,
	input  logic signed [COORD_WIDTH-1:0] b_start_y,
	input  logic signed [COORD_WIDTH-1:0] b_end_x,
	input  logic signed [COORD_WIDTH-1:0] b_end_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] meet_x,
	output logic signed [COORD_WIDTH-1:0] meet_y,
	output logic                          is_parallel
);
	localparam int unsigned CW = COORD_WIDTH;
	localparam int unsigned DW = CW + 1;
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned NW = PW + 1;
	localparam int unsigned MW = NW + DW;
	localparam int unsigned QW = CW + 2;

	typedef struct packed {
		logic          hit;
		logic          par;
		logic          neg;
		logic [CW-1:0] base;
	} tag_t;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1, wx_s1, wy_s1;
	logic signed [CW-1:0] ax_s1, ay_s1, ax_s2, ay_s2, ax_s3, ay_s3;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [DW-1:0] dax_s2, day_s2, dax_s3, day_s3;
	logic signed [NW-1:0] den_s3, un_s3, tn_s3;
	logic                 hit_s4, par_s4;
	logic signed [MW-1:0] mx_s4, my_s4;
	logic [NW-1:0]        dmag_s4;
	logic signed [CW-1:0] ax_s4, ay_s4;
	logic                 dsg_s4;
	logic                 hit_c;
	logic                 dvx, dvy;
	logic [QW-1:0]        qx, qy;
	tag_t                 tx_in, ty_in, tx, ty;
	logic                 r_v_q, r_hit_q, r_par_q;
	logic [CW-1:0]        r_x_q, r_y_q;

	assign adv = !(r_v_q && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	function automatic logic in_unit(logic signed [NW-1:0] n, logic signed [NW-1:0] d);
		if (!d[NW-1]) begin
			return !n[NW-1] && (n <= d);
		end
		return (n[NW-1] || n == '0) && (n >= d);
	endfunction

	always_comb begin
		hit_c = (den_s3 != '0) && in_unit(un_s3, den_s3) && in_unit(tn_s3, den_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dax_s1 <= DW'(a_end_x) - DW'(a_start_x);
			day_s1 <= DW'(a_end_y) - DW'(a_start_y);
			dbx_s1 <= DW'(b_end_x) - DW'(b_start_x);
			dby_s1 <= DW'(b_end_y) - DW'(b_start_y);
			wx_s1 <= DW'(a_start_x) - DW'(b_start_x);
			wy_s1 <= DW'(a_start_y) - DW'(b_start_y);
			ax_s1 <= a_start_x;
			ay_s1 <= a_start_y;

			p0_s2 <= PW'(dax_s1) * PW'(dby_s1);
			p1_s2 <= PW'(dbx_s1) * PW'(day_s1);
			p2_s2 <= PW'(dax_s1) * PW'(wy_s1);
			p3_s2 <= PW'(day_s1) * PW'(wx_s1);
			p4_s2 <= PW'(dbx_s1) * PW'(wy_s1);
			p5_s2 <= PW'(dby_s1) * PW'(wx_s1);
			dax_s2 <= dax_s1;
			day_s2 <= day_s1;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;

			den_s3 <= NW'(p0_s2) - NW'(p1_s2);
			un_s3 <= NW'(p2_s2) - NW'(p3_s2);
			tn_s3 <= NW'(p4_s2) - NW'(p5_s2);
			dax_s3 <= dax_s2;
			day_s3 <= day_s2;
			ax_s3 <= ax_s2;
			ay_s3 <= ay_s2;

			hit_s4 <= hit_c;
			par_s4 <= den_s3 == '0;
			mx_s4 <= MW'(tn_s3) * MW'(dax_s3);
			my_s4 <= MW'(tn_s3) * MW'(day_s3);
			dmag_s4 <= den_s3[NW-1] ? NW'(-den_s3) : NW'(den_s3);
			dsg_s4 <= den_s3[NW-1];
			ax_s4 <= ax_s3;
			ay_s4 <= ay_s3;
		end
	end

	logic [MW-1:0] mxa, mya;
	logic [NW:0]   dm_ext;
	assign mxa = mx_s4[MW-1] ? MW'(-mx_s4) : MW'(mx_s4);
	assign mya = my_s4[MW-1] ? MW'(-my_s4) : MW'(my_s4);
	assign dm_ext = {1'b0, dmag_s4};
	assign tx_in = '{hit: hit_s4, par: par_s4, neg: mx_s4[MW-1] ^ dsg_s4,
		base: ax_s4};
	assign ty_in = '{hit: hit_s4, par: par_s4, neg: my_s4[MW-1] ^ dsg_s4,
		base: ay_s4};

	segi_div #(.NUM_W(MW), .DEN_W(NW + 1), .Q_W(QW), .TAG_W(CW + 3)) u_divx (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s4),
		.num(mxa), .den(dm_ext), .tag_in(tx_in),
		.out_valid(dvx), .quo(qx), .tag_out(tx)
	);

	segi_div #(.NUM_W(MW), .DEN_W(NW + 1), .Q_W(QW), .TAG_W(CW + 3)) u_divy (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_valid(v_s4),
		.num(mya), .den(dm_ext), .tag_in(ty_in),
		.out_valid(dvy), .quo(qy), .tag_out(ty)
	);

	logic [QW-1:0] ox, oy;
	assign ox = tx.neg ? QW'(-qx) : qx;
	assign oy = ty.neg ? QW'(-qy) : qy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_v_q <= 1'b0;
		end else if (adv) begin
			r_v_q <= dvx && dvy;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_hit_q <= tx.hit;
			r_par_q <= tx.par;
			r_x_q <= tx.hit ? CW'(tx.base + CW'(ox)) : '0;
			r_y_q <= ty.hit ? CW'(ty.base + CW'(oy)) : '0;
		end
	end

	assign out_valid = r_v_q;
	assign hit = r_hit_q;
	assign is_parallel = r_par_q;
	assign meet_x = r_x_q;
	assign meet_y = r_y_q;

`ifndef NO_ASSERTIONS
	a_hit_par: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && is_parallel)) else $error("hit and parallel together");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (meet_x == '0 && meet_y == '0))
		else $error("point not zero on miss");
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		dvx == dvy) else $error("divider lanes out of step");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(meet_x) && $stable(hit)))
		else $error("stalled result changed");
`endif
endmodule
